[rtl/core/cfp_pkg.sv]
package cfp_pkg;

   // Framing constants
   localparam logic [7:0]  SYNC_BYTE   = 8'hA5;
   localparam logic [7:0]  TYPE_SET    = 8'h01;
   localparam logic [7:0]  TYPE_GET    = 8'h02;
   localparam logic [15:0] CRC_POLY    = 16'h1021;
   localparam logic [15:0] CRC_INIT    = 16'hFFFF;
   localparam logic [15:0] LIMIT_RESET = 16'd64;

   // Event codes on the input word
   localparam logic CMD_BYTE    = 1'b0;
   localparam logic CMD_TIMEOUT = 1'b1;

   // Result kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_FRAME   = 1'b1;

   // Frame status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_CRC      = 2'd1;
   localparam logic [1:0] STATUS_LOCKED   = 2'd2;
   localparam logic [1:0] STATUS_OVERSIZE = 2'd3;

   // Register indexes on the control port
   localparam logic [1:0] CSR_BULK_CODE = 2'd0;
   localparam logic [1:0] CSR_BULK_MIN  = 2'd1;
   localparam logic [1:0] CSR_BULK_MAX  = 2'd2;
   localparam logic [1:0] CSR_LIMIT     = 2'd3;

   typedef struct packed {
      logic       command;
      logic [7:0] rx_byte;
      logic       bulk_grant;
   } req_word_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  data_byte;
      logic [15:0] byte_offset;
      logic        to_bulk_buffer;
      logic        is_read;
      logic [7:0]  request_code;
      logic [15:0] request_value;
      logic [15:0] request_index;
      logic [15:0] request_length;
      logic [1:0]  frame_status;
   } rsp_word_type;

   // Control register set as seen by the parser
   typedef struct packed {
      logic [7:0]  bulk_request_code;
      logic [15:0] bulk_min_length;
      logic [15:0] bulk_max_length;
      logic [15:0] payload_limit;
   } cfg_type;

   // One byte of CRC16-CCITT-FALSE, unrolled over the eight bit steps.
   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] v;
      v = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (v[15]) begin
            v = {v[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            v = {v[14:0], 1'b0};
         end
      end
      return v;
   endfunction

endpackage

[rtl/core/cfp_parser.sv]
module cfp_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  cfp_pkg::req_word_type word,
   input  cfp_pkg::cfg_type      cfg,
   output logic                  result_valid,
   output cfp_pkg::rsp_word_type result
);

   typedef enum logic [2:0] {
      PH_SYNC,
      PH_TYPE,
      PH_HEADER,
      PH_PAYLOAD,
      PH_CRC
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic        read_frame_ff, read_frame_in;
   logic [2:0]  header_count_ff, header_count_in;
   logic [7:0]  req_code_ff, req_code_in;
   logic [15:0] req_value_ff, req_value_in;
   logic [15:0] req_index_ff, req_index_in;
   logic [15:0] req_length_ff, req_length_in;
   logic [15:0] payload_count_ff, payload_count_in;
   logic        discarding_ff, discarding_in;
   logic        bulk_route_ff, bulk_route_in;
   logic [1:0]  held_status_ff, held_status_in;
   logic [15:0] crc_ff, crc_in;
   logic        crc_byte_count_ff, crc_byte_count_in;
   logic [7:0]  crc_low_ff, crc_low_in;

   logic [7:0]  b;
   logic [15:0] crc_next;
   logic [15:0] full_length;
   logic [15:0] count_next;
   logic [15:0] received_crc;
   logic [1:0]  status;
   logic        is_bulk;

   assign b            = word.rx_byte;
   assign crc_next     = cfp_pkg::crc_update(crc_ff, b);
   assign full_length  = {b, req_length_ff[7:0]};
   assign count_next   = payload_count_ff + 16'd1;
   assign received_crc = {b, crc_low_ff};
   assign is_bulk      = (req_code_ff == cfg.bulk_request_code) &&
                         (full_length >= cfg.bulk_min_length) &&
                         (full_length <= cfg.bulk_max_length);

   // Status of a finished frame: a CRC mismatch wins over any held status.
   always_comb begin
      if (received_crc != crc_ff) begin
         status = cfp_pkg::STATUS_CRC;
      end else if (discarding_ff) begin
         status = held_status_ff;
      end else begin
         status = cfp_pkg::STATUS_OK;
      end
   end

   // Next state and the result of the word being taken.
   always_comb begin
      phase_in          = phase_ff;
      read_frame_in     = read_frame_ff;
      header_count_in   = header_count_ff;
      req_code_in       = req_code_ff;
      req_value_in      = req_value_ff;
      req_index_in      = req_index_ff;
      req_length_in     = req_length_ff;
      payload_count_in  = payload_count_ff;
      discarding_in     = discarding_ff;
      bulk_route_in     = bulk_route_ff;
      held_status_in    = held_status_ff;
      crc_in            = crc_ff;
      crc_byte_count_in = crc_byte_count_ff;
      crc_low_in        = crc_low_ff;
      result_valid      = 1'b0;
      result            = '0;

      if (step) begin
         if (word.command == cfp_pkg::CMD_TIMEOUT) begin
            // Abandon any partial frame.
            phase_in          = PH_SYNC;
            header_count_in   = 3'd0;
            payload_count_in  = 16'd0;
            discarding_in     = 1'b0;
            bulk_route_in     = 1'b0;
            crc_byte_count_in = 1'b0;
         end else begin
            unique case (phase_ff)
               PH_SYNC: begin
                  if (b == cfp_pkg::SYNC_BYTE) begin
                     phase_in = PH_TYPE;
                  end
               end
               PH_TYPE: begin
                  if (b == cfp_pkg::TYPE_SET || b == cfp_pkg::TYPE_GET) begin
                     read_frame_in   = (b == cfp_pkg::TYPE_GET);
                     crc_in          = cfp_pkg::crc_update(cfp_pkg::CRC_INIT, b);
                     header_count_in = 3'd0;
                     phase_in        = PH_HEADER;
                  end else begin
                     phase_in = PH_SYNC;
                  end
               end
               PH_HEADER: begin
                  crc_in = crc_next;
                  unique case (header_count_ff)
                     3'd0:    req_code_in   = b;
                     3'd1:    req_value_in  = {req_value_ff[15:8], b};
                     3'd2:    req_value_in  = {b, req_value_ff[7:0]};
                     3'd3:    req_index_in  = {req_index_ff[15:8], b};
                     3'd4:    req_index_in  = {b, req_index_ff[7:0]};
                     3'd5:    req_length_in = {req_length_ff[15:8], b};
                     default: req_length_in = full_length;
                  endcase
                  if (header_count_ff >= 3'd6) begin
                     // Header complete: decide the payload route.
                     header_count_in   = 3'd0;
                     discarding_in     = 1'b0;
                     bulk_route_in     = 1'b0;
                     payload_count_in  = 16'd0;
                     held_status_in    = cfp_pkg::STATUS_OK;
                     crc_byte_count_in = 1'b0;
                     if (read_frame_ff || full_length == 16'd0) begin
                        phase_in = PH_CRC;
                     end else begin
                        phase_in = PH_PAYLOAD;
                        if (is_bulk) begin
                           if (word.bulk_grant) begin
                              bulk_route_in = 1'b1;
                           end else begin
                              discarding_in  = 1'b1;
                              held_status_in = cfp_pkg::STATUS_LOCKED;
                           end
                        end else if (full_length > cfg.payload_limit) begin
                           discarding_in  = 1'b1;
                           held_status_in = cfp_pkg::STATUS_OVERSIZE;
                        end
                     end
                  end else begin
                     header_count_in = header_count_ff + 3'd1;
                  end
               end
               PH_PAYLOAD: begin
                  crc_in = crc_next;
                  if (!discarding_ff) begin
                     result_valid          = 1'b1;
                     result.kind           = cfp_pkg::KIND_PAYLOAD;
                     result.data_byte      = b;
                     result.byte_offset    = payload_count_ff;
                     result.to_bulk_buffer = bulk_route_ff;
                  end
                  payload_count_in = count_next;
                  if (count_next == req_length_ff) begin
                     crc_byte_count_in = 1'b0;
                     phase_in          = PH_CRC;
                  end
               end
               PH_CRC: begin
                  if (!crc_byte_count_ff) begin
                     crc_low_in        = b;
                     crc_byte_count_in = 1'b1;
                  end else begin
                     result_valid          = 1'b1;
                     result.kind           = cfp_pkg::KIND_FRAME;
                     result.to_bulk_buffer = (status == cfp_pkg::STATUS_OK) && bulk_route_ff;
                     result.is_read        = read_frame_ff;
                     result.request_code   = req_code_ff;
                     result.request_value  = req_value_ff;
                     result.request_index  = req_index_ff;
                     result.request_length = req_length_ff;
                     result.frame_status   = status;
                     phase_in              = PH_SYNC;
                     crc_byte_count_in     = 1'b0;
                     discarding_in         = 1'b0;
                  end
               end
               default: begin
                  phase_in          = PH_SYNC;
                  header_count_in   = 3'd0;
                  payload_count_in  = 16'd0;
                  discarding_in     = 1'b0;
                  bulk_route_in     = 1'b0;
                  crc_byte_count_in = 1'b0;
               end
            endcase
         end
      end
   end

   // Parser state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_SYNC;
         read_frame_ff     <= 1'b0;
         header_count_ff   <= 3'd0;
         req_code_ff       <= 8'd0;
         req_value_ff      <= 16'd0;
         req_index_ff      <= 16'd0;
         req_length_ff     <= 16'd0;
         payload_count_ff  <= 16'd0;
         discarding_ff     <= 1'b0;
         bulk_route_ff     <= 1'b0;
         held_status_ff    <= cfp_pkg::STATUS_OK;
         crc_ff            <= cfp_pkg::CRC_INIT;
         crc_byte_count_ff <= 1'b0;
         crc_low_ff        <= 8'd0;
      end else begin
         phase_ff          <= phase_in;
         read_frame_ff     <= read_frame_in;
         header_count_ff   <= header_count_in;
         req_code_ff       <= req_code_in;
         req_value_ff      <= req_value_in;
         req_index_ff      <= req_index_in;
         req_length_ff     <= req_length_in;
         payload_count_ff  <= payload_count_in;
         discarding_ff     <= discarding_in;
         bulk_route_ff     <= bulk_route_in;
         held_status_ff    <= held_status_in;
         crc_ff            <= crc_in;
         crc_byte_count_ff <= crc_byte_count_in;
         crc_low_ff        <= crc_low_in;
      end
   end

endmodule

[rtl/core/control_frame_parser.sv]
// Channel   Direction  Ports                                    Word
// req       in         req_valid, req_ready, req_data           command, rx_byte, bulk_grant
// rsp       out        rsp_valid, rsp_ready, rsp_data           payload byte or frame result
// csr       in         csr_we, csr_index, csr_wdata             control register write
//
// One word is taken per cycle while the output is not stalled; its result, if any,
// appears in the output register on the following cycle.
// The parser state and CRC are updated in the cycle the word is taken.
// Reset is synchronous and returns the parser to sync hunting with default registers.
// A stalled output holds its word; a new word is taken only when the output
// register is empty or being emptied in the same cycle.
module control_frame_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cfp_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output cfp_pkg::rsp_word_type rsp_data,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_wdata
);

   cfp_pkg::cfg_type      cfg_ff;
   logic                  rsp_valid_ff;
   cfp_pkg::rsp_word_type rsp_data_ff;
   logic                  step;
   logic                  result_valid;
   cfp_pkg::rsp_word_type result;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bulk_request_code <= 8'd0;
         cfg_ff.bulk_min_length   <= 16'd0;
         cfg_ff.bulk_max_length   <= 16'hFFFF;
         cfg_ff.payload_limit     <= cfp_pkg::LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            cfp_pkg::CSR_BULK_CODE: cfg_ff.bulk_request_code <= csr_wdata[7:0];
            cfp_pkg::CSR_BULK_MIN:  cfg_ff.bulk_min_length   <= csr_wdata;
            cfp_pkg::CSR_BULK_MAX:  cfg_ff.bulk_max_length   <= csr_wdata;
            cfp_pkg::CSR_LIMIT:     cfg_ff.payload_limit     <= csr_wdata;
            default:                cfg_ff <= cfg_ff;
         endcase
      end
   end

   cfp_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .word         (req_data),
      .cfg          (cfg_ff),
      .result_valid (result_valid),
      .result       (result)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step && result_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && result_valid) begin
         rsp_data_ff <= result;
      end
   end

endmodule

[rtl/core/cfp_checker.sv]
module cfp_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input cfp_pkg::req_word_type req_data,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input cfp_pkg::rsp_word_type rsp_data
);

   // Reset leaves no word in the output register.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("output word present after reset");

   // An empty output register never holds back the input.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   // A new output word comes only from a word taken on the cycle before.
   a_result_has_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("output word without an input word");

   // A timeout never yields a result.
   a_timeout_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.command == cfp_pkg::CMD_TIMEOUT) |=> !rsp_valid)
      else $error("result after timeout");

   // A stalled output word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled output word changed");

endmodule

bind control_frame_parser cfp_checker u_cfp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
